/* rtl/cxd_pkg.sv */
// Shared types, codes and constants of the confinement depth block.
`timescale 1ns / 1ps
package cxd_pkg;

    // field widths
    localparam int CMD_W      = 1;
    localparam int IN_IDX_W   = 11;
    localparam int VAL_W      = 14;
    localparam int SEED_W     = 64;
    localparam int DEPTH_W    = 11;
    localparam int BITLEN_W   = 7;
    localparam int Q_W        = 8;
    localparam int R_W        = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ORBIT_W    = 128;
    localparam int STRIP_W    = 16;
    localparam int ZCNT_W     = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_EVAL = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDEND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 8'd3;

    // multipliers above this value use the upper rare side
    localparam logic [Q_W-1:0] Q_SPLIT = 8'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_WAIT, ST_CHECK, ST_DONE
    } t_ctl_state;

    typedef enum logic [1:0] {
        MS_IDLE, MS_MUL, MS_ADD, MS_STRIP
    } t_map_state;

    typedef struct packed {
        logic load;
        logic start;
    } t_map_ctl;

    typedef struct packed {
        logic              done;
        logic              fail;
        logic [ZCNT_W-1:0] twos;
    } t_map_sts;

    // residue modulo 3 of a 7-bit value, by base-4 digit folding
    function automatic logic [1:0] mod3_7(input logic [6:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[6]);
        if (s >= 4'd9)      s = s - 4'd9;
        else if (s >= 4'd6) s = s - 4'd6;
        else if (s >= 4'd3) s = s - 4'd3;
        return s[1:0];
    endfunction

endpackage

/* rtl/cxd_if.sv */
// Channel interfaces: input items, result items and register writes.
`timescale 1ns / 1ps
interface cxd_in_if import cxd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [IN_IDX_W-1:0] table_index;
    logic [VAL_W-1:0]    table_value;
    logic [SEED_W-1:0]   seed;
    modport source (output valid, command, table_index, table_value, seed, input ready);
    modport sink   (input valid, command, table_index, table_value, seed, output ready);
endinterface

interface cxd_out_if import cxd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  depth;
    logic                guard_hit;
    logic [BITLEN_W-1:0] bit_length;
    logic                chain_root;
    logic                is_deep;
    modport source (output valid, depth, guard_hit, bit_length, chain_root, is_deep,
                    input ready);
    modport sink   (input valid, depth, guard_hit, bit_length, chain_root, is_deep,
                    output ready);
endinterface

interface cxd_cfg_if import cxd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/cxd_table_mem.sv */
// Bound table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module cxd_table_mem #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11,
    parameter int DW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

/* rtl/cxd_map_unit.sv */
// One map step: multiply, add, then strip factors of two 16 bits a cycle.
`timescale 1ns / 1ps
module cxd_map_unit import cxd_pkg::*; #(
    parameter int GUARD_EXPONENT = 118
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_map_ctl            i_ctl,
    input  logic [SEED_W-1:0]   i_seed,
    input  logic [Q_W-1:0]      i_q,
    input  logic [R_W-1:0]      i_r,
    output t_map_sts            o_sts
);
    t_map_state r_state, n_state;
    logic [ORBIT_W-1:0] r_x, r_p;
    logic [ZCNT_W-1:0]  r_a;
    logic               r_done, r_fail;

    logic [R_W+Q_W-1:0] w_part [4];
    logic [ORBIT_W-1:0] w_prod;
    logic [ORBIT_W+1:0] w_sum;
    logic               w_bad;
    logic [STRIP_W-1:0] w_low;
    logic [3:0]         w_ctz;

    // partial products of x by q
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_part[i] = r_x[32*i +: 32] * i_q;
        end
        w_prod = ORBIT_W'(w_part[0]) + (ORBIT_W'(w_part[1]) << 32)
               + (ORBIT_W'(w_part[2]) << 64) + (ORBIT_W'(w_part[3]) << 96);
    end

    // add r and flag zero, negative or guard-sized values
    assign w_sum = {2'b00, r_p} + {{(ORBIT_W + 2 - R_W){i_r[R_W-1]}}, i_r};
    assign w_bad = w_sum[ORBIT_W+1] || (w_sum == '0)
                || ((w_sum[ORBIT_W-1:0] >> GUARD_EXPONENT) != '0);

    // trailing zeros of the low chunk
    assign w_low = r_x[STRIP_W-1:0];
    always_comb begin
        w_ctz = '0;
        for (int i = STRIP_W - 1; i >= 0; i--) begin
            if (w_low[i]) w_ctz = 4'(i);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE:  if (i_ctl.start) n_state = MS_MUL;
            MS_MUL:   n_state = MS_ADD;
            MS_ADD:   n_state = w_bad ? MS_IDLE : MS_STRIP;
            MS_STRIP: if (w_low != '0) n_state = MS_IDLE;
            default:  n_state = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
            r_fail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == MS_ADD) && w_bad)
                    || ((r_state == MS_STRIP) && (w_low != '0));
            if (r_state == MS_ADD) r_fail <= w_bad;
        end
    end

    // datapath: load seed, multiply, add, shift out twos
    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_ctl.load) begin
            r_x <= {{(ORBIT_W - SEED_W){1'b0}}, i_seed};
        end
        if (r_state == MS_MUL) begin
            r_p <= w_prod;
        end
        if (r_state == MS_ADD && !w_bad) begin
            r_x <= w_sum[ORBIT_W-1:0];
            r_a <= '0;
        end
        if (r_state == MS_STRIP) begin
            if (w_low == '0) begin
                r_x <= r_x >> STRIP_W;
                r_a <= r_a + ZCNT_W'(STRIP_W);
            end else begin
                r_x <= r_x >> w_ctz;
                r_a <= r_a + ZCNT_W'(w_ctz);
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.fail = r_fail;
    assign o_sts.twos = r_a;
endmodule

/* rtl/cxd_seed_info.sv */
// Seed bit length and residue class, captured when a seed is taken.
`timescale 1ns / 1ps
module cxd_seed_info import cxd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_capture,
    input  logic [SEED_W-1:0]   i_seed,
    output logic [BITLEN_W-1:0] o_bit_length,
    output logic                o_chain_root
);
    logic [SEED_W-1:0] r_seed;
    logic [7:0]        r_bnz;
    logic [6:0]        r_dsum;
    logic [6:0]        w_dsum;
    logic [2:0]        w_bsel, w_msb;
    logic [7:0]        w_byte;

    // base-4 digit sum, same residue mod 3 as the seed
    always_comb begin
        w_dsum = '0;
        for (int i = 0; i < SEED_W / 2; i++) begin
            w_dsum = w_dsum + 7'(i_seed[2*i +: 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_seed <= i_seed;
            r_dsum <= w_dsum;
            for (int j = 0; j < 8; j++) begin
                r_bnz[j] <= (i_seed[8*j +: 8] != '0);
            end
        end
    end

    // highest nonzero byte, then its top bit
    always_comb begin
        w_bsel = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_bnz[j]) w_bsel = 3'(j);
        end
        w_byte = r_seed[8*w_bsel +: 8];
        w_msb  = '0;
        for (int i = 0; i < 8; i++) begin
            if (w_byte[i]) w_msb = 3'(i);
        end
    end

    assign o_bit_length = (r_bnz == '0) ? '0
                        : BITLEN_W'({w_bsel, w_msb}) + BITLEN_W'(1);
    assign o_chain_root = (mod3_7(r_dsum) != 2'd2);
endmodule

/* rtl/qx_plus_r_confinement_depth.sv */
// Top level of the confinement depth block: control, registers and result stage.
//
//  channel   direction  handshake     payload
//  i_in      in         valid/ready   command, table_index, table_value, seed
//  o_out     out        valid/ready   depth, guard_hit, bit_length, chain_root, is_deep
//  i_cfg     in         valid/ready   index, data (ready always high)
//
// A seed runs a series of map steps; each step goes through start, multiply and add,
// then strip steps of up to 16 bits each, a table lookup and a check; a step that
// ends at the guard skips the strip, lookup and check.
// The step count is set by the orbit, the bound table and the cap.
// Reset is synchronous; the bound table is not cleared and must be loaded.
// A result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module qx_plus_r_confinement_depth import cxd_pkg::*; #(
    parameter int MAX_DEPTH      = 1024,
    parameter int GUARD_EXPONENT = 118
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cxd_in_if.sink    i_in,
    cxd_out_if.source o_out,
    cxd_cfg_if.sink   i_cfg
);
    localparam int KW = $clog2(MAX_DEPTH + 1);
    localparam int TW = $clog2(MAX_DEPTH * 128 + 1);
    localparam int CW = (KW > DEPTH_W) ? KW : DEPTH_W;

    t_ctl_state r_state, n_state;
    logic [Q_W-1:0]     r_q;
    logic [R_W-1:0]     r_r;
    logic [DEPTH_W-1:0] r_deep, r_cap;
    logic [KW-1:0]      r_k;
    logic [TW-1:0]      r_twos;
    logic               r_guard;

    t_map_ctl w_ctl;
    t_map_sts w_sts;
    logic               w_in_acc, w_load, w_eval, w_we, w_re, w_ok, w_last, w_out_free;
    logic [KW-1:0]      w_k_next;
    logic [CW-1:0]      w_cap;
    logic [VAL_W-1:0]   w_bound;
    logic [BITLEN_W-1:0] w_bitlen;
    logic               w_root;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_load     = w_in_acc && (i_in.command == CMD_LOAD);
    assign w_eval     = w_in_acc && (i_in.command == CMD_EVAL);
    assign w_out_free = !o_out.valid || o_out.ready;
    assign w_k_next   = r_k + KW'(1);
    assign w_cap      = (CW'(r_cap) > CW'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(r_cap);
    assign w_we       = w_load && (CW'(i_in.table_index) <= CW'(MAX_DEPTH));
    assign w_re       = (r_state == ST_WAIT) && w_sts.done && !w_sts.fail;
    assign w_ok       = (r_q > Q_SPLIT) ? (r_twos > TW'(w_bound)) : (r_twos <= TW'(w_bound));
    assign w_last     = CW'(w_k_next) >= w_cap;

    // register writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= Q_W'(3);
            r_r    <= R_W'(1);
            r_deep <= DEPTH_W'(1025);
            r_cap  <= DEPTH_W'(1024);
        end else if (i_cfg.valid) begin
            priority case (i_cfg.index)
                CFG_MULT:   r_q    <= i_cfg.data[Q_W-1:0];
                CFG_ADDEND: r_r    <= i_cfg.data[R_W-1:0];
                CFG_DEEP:   r_deep <= i_cfg.data[DEPTH_W-1:0];
                CFG_CAP:    r_cap  <= i_cfg.data[DEPTH_W-1:0];
                default:    ;
            endcase
        end
    end

    cxd_table_mem #(.DEPTH(MAX_DEPTH + 1), .AW(KW), .DW(VAL_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (KW'(i_in.table_index)),
        .i_wdata (i_in.table_value),
        .i_re    (w_re),
        .i_raddr (w_k_next),
        .o_rdata (w_bound)
    );

    cxd_map_unit #(.GUARD_EXPONENT(GUARD_EXPONENT)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_seed  (i_in.seed),
        .i_q     (r_q),
        .i_r     (r_r),
        .o_sts   (w_sts)
    );

    cxd_seed_info u_info (
        .i_clk        (i_clk),
        .i_capture    (w_eval),
        .i_seed       (i_in.seed),
        .o_bit_length (w_bitlen),
        .o_chain_root (w_root)
    );

    // sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        w_ctl.load  = 1'b0;
        w_ctl.start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                w_ctl.load = w_eval;
                if (w_eval) n_state = ST_START;
            end
            ST_START: begin
                w_ctl.start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_sts.done) n_state = w_sts.fail ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (!w_ok || w_last) ? ST_DONE : ST_START;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_twos  <= '0;
            r_guard <= 1'b0;
        end else begin
            if (w_eval) begin
                r_k     <= '0;
                r_twos  <= '0;
                r_guard <= 1'b0;
            end
            if (r_state == ST_WAIT && w_sts.done) begin
                if (w_sts.fail) r_guard <= 1'b1;
                else            r_twos  <= r_twos + TW'(w_sts.twos);
            end
            if (r_state == ST_CHECK && w_ok) begin
                r_k <= w_k_next;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            o_out.depth      <= DEPTH_W'(r_k);
            o_out.guard_hit  <= r_guard;
            o_out.bit_length <= w_bitlen;
            o_out.chain_root <= w_root;
            o_out.is_deep    <= (CW'(r_k) >= CW'(r_deep));
        end
    end
endmodule

/* rtl/cxd_checker.sv */
// Port-level checks of the confinement depth block, bound to the top level.
`timescale 1ns / 1ps
module cxd_checker import cxd_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic [CMD_W-1:0]    i_in_command,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [BITLEN_W-1:0] i_out_bit_length,
    input logic                i_out_chain_root
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a table load never busies the input
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_LOAD) |=> i_in_ready)
        else $error("input stalled after table load");

    // a seed busies the input until its result is stored
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_EVAL) |=> !i_in_ready)
        else $error("input ready while seed in progress");

    // a new result follows a busy period
    a_out_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without a seed walk");

    // a zero seed lies in a root class
    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_bit_length == '0) |-> i_out_chain_root)
        else $error("zero seed not flagged as root");
endmodule

bind qx_plus_r_confinement_depth cxd_checker u_cxd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_command     (i_in.command),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_bit_length (o_out.bit_length),
    .i_out_chain_root (o_out.chain_root)
);
